### rtl/dbwc_pkg.sv
// dbwc_pkg: word types, register indexes and fixed constants of the delay-based window controller
// no dependencies; used by every rtl file of the block that needs shared types
package dbwc_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 17;
    localparam int GAIN_W      = 17;
    localparam int VEL_W       = 5;
    localparam int TIME_W      = 32;
    localparam int EST_W       = 48;
    localparam int TIMEOUT_W   = 35;
    localparam int PKT_W       = 9;
    localparam int MUL_CNT_W   = 5;

    localparam logic [CFG_INDEX_W-1:0] CFG_GAIN     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_VELOCITY = 2'd1;

    localparam logic [GAIN_W-1:0]    GAIN_ONE      = 17'd65536;
    localparam logic [GAIN_W-1:0]    GAIN_RESET    = 17'd6554;
    localparam logic [VEL_W-1:0]     VEL_RESET     = 5'd1;
    localparam logic [TIME_W-1:0]    LOWEST_RESET  = 32'd100000000;
    localparam logic [MUL_CNT_W-1:0] MUL_LAST      = 5'd16;

    typedef struct packed {
        logic [TIME_W-1:0] send_time_ms;
        logic [TIME_W-1:0] ack_time_ms;
    } ack_word_t;

    typedef struct packed {
        logic [PKT_W-1:0]     window_packets;
        logic [TIMEOUT_W-1:0] rto_ms;
        logic                 congested;
        logic                 in_slow_start;
    } res_word_t;

endpackage

### rtl/dbwc_ram.sv
// dbwc_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module dbwc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/dbwc_div.sv
// dbwc_div: restoring divider, one quotient bit per cycle
// no dependencies; used by the top level for the window step
module dbwc_div #(
    parameter int NUM_W = 37,
    parameter int DEN_W = 25
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [NUM_W-1:0] num_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             qbit;

    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign qbit  = trial >= {1'b0, divisor};
    assign diff  = trial - {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
                rem_reg  <= '0;
                num_reg  <= dividend;
            end
            else if (busy_reg)
            begin
                rem_reg <= qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                num_reg <= {num_reg[NUM_W-2:0], qbit};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = num_reg;

endmodule

### rtl/delay_based_window_controller_core.sv
// delay_based_window_controller_core: top level, rtt tracking, history scan and window update
// depends on dbwc_pkg, dbwc_ram, dbwc_div
//
//  channel | signals                          | direction
//  ack     | ack_valid ack_ready ack_word     | in
//  res     | res_valid res_ready res_word     | out
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data | in
//
// one ack at a time; each ack runs the 17-step ewma shift-add, the one-read-a-cycle scan of
// the live history entries (up to 256) and the bit-serial divider. history ram needs no
// clearing after reset.
// ack_ready is low while an ack is in work; a stalled result holds the last step until taken.
module delay_based_window_controller_core #(
    parameter int HISTORY_DEPTH    = 256,
    parameter int WINDOW_FRAC_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 ack_valid,
    output logic                                 ack_ready,
    input  dbwc_pkg::ack_word_t                  ack_word,
    output logic                                 res_valid,
    input  logic                                 res_ready,
    output dbwc_pkg::res_word_t                  res_word,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [dbwc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [dbwc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int F    = WINDOW_FRAC_BITS;
    localparam int HW   = $clog2(HISTORY_DEPTH);
    localparam int CW   = $clog2(HISTORY_DEPTH + 1);
    localparam int WW   = dbwc_pkg::PKT_W + F;
    localparam int NW   = dbwc_pkg::VEL_W + 2 * F;
    localparam int XW   = NW + 1;
    localparam int CMPW = CW + 8;
    localparam int PW   = WW + dbwc_pkg::TIME_W;
    localparam int EW   = dbwc_pkg::EST_W;
    localparam int AW   = EW + 1 + dbwc_pkg::GAIN_W;

    localparam logic [WW-1:0] W_ONE = WW'(1) << F;
    localparam logic [WW-1:0] W_MAX = WW'(511) << F;
    localparam logic [HW-1:0] H_LAST = HW'(HISTORY_DEPTH - 1);
    localparam logic [CW-1:0] H_FULL = CW'(HISTORY_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE, S_WR, S_MUL, S_SCAN, S_MULQ, S_CMP, S_DIV, S_FIN
    } state_t;

    state_t                          state_reg;
    logic [dbwc_pkg::GAIN_W-1:0]     gain_reg;
    logic [dbwc_pkg::VEL_W-1:0]      vel_reg;
    logic [WW-1:0]                   window_reg;
    logic                            slow_reg;
    logic [EW-1:0]                   est_reg;
    logic [dbwc_pkg::TIME_W-1:0]     lowest_reg;
    logic [HW-1:0]                   head_reg;
    logic [CW-1:0]                   count_reg;
    logic [dbwc_pkg::TIME_W-1:0]     sample_reg;
    logic                            first_reg;
    logic [AW-1:0]                   acc_reg;
    logic [AW-1:0]                   mcand_reg;
    logic [dbwc_pkg::GAIN_W-1:0]     gsh_reg;
    logic [dbwc_pkg::MUL_CNT_W-1:0]  mul_cnt_reg;
    logic [HW-1:0]                   scan_addr_reg;
    logic [CW-1:0]                   scan_left_reg;
    logic                            rd_pend_reg;
    logic [dbwc_pkg::TIME_W-1:0]     standing_reg;
    logic [PW-1:0]                   prod_reg;
    logic                            cong_reg;
    logic                            res_valid_reg;
    dbwc_pkg::res_word_t             res_word_reg;

    logic [dbwc_pkg::TIME_W-1:0]     sample_next;
    logic [dbwc_pkg::GAIN_W-1:0]     gain_eff;
    logic [EW-1:0]                   s_fixed;
    logic [EW:0]                     diff_next;
    logic [EW+1:0]                   est_sum;
    logic [EW-1:0]                   est_next;
    logic [7:0]                      tau;
    logic [CW:0]                     wsum;
    logic [HW-1:0]                   waddr;
    logic [HW-1:0]                   head1;
    logic [CW-1:0]                   count1;
    logic [HW-1:0]                   head_next;
    logic [CW-1:0]                   count_next;
    logic                            we;
    logic [dbwc_pkg::TIME_W-1:0]     rdata;
    logic [dbwc_pkg::TIME_W-1:0]     queueing;
    logic                            div_start;
    logic                            div_done;
    logic [NW-1:0]                   quotient;
    logic [XW-1:0]                   w_x;
    logic [XW-1:0]                   d_x;
    logic [XW-1:0]                   nw_x;
    logic [WW-1:0]                   window_next;
    logic                            slow_next;
    logic [EW+2:0]                   t5;

    function automatic logic [HW-1:0] wrap_inc(input logic [HW-1:0] a);
        wrap_inc = (a == H_LAST) ? '0 : a + 1'b1;
    endfunction

    assign sample_next = ack_word.ack_time_ms - ack_word.send_time_ms;
    assign gain_eff    = (gain_reg > dbwc_pkg::GAIN_ONE) ? dbwc_pkg::GAIN_ONE : gain_reg;
    assign s_fixed     = {sample_reg, 16'd0};
    assign diff_next   = {1'b0, s_fixed} - {1'b0, est_reg};
    assign est_sum     = {2'b00, est_reg} + acc_reg[AW-1:16];
    assign est_next    = first_reg ? s_fixed : est_sum[EW-1:0];

    assign tau = (window_reg[WW-1:F+1] == '0) ? 8'd1 : window_reg[WW-1:F+1];

    assign wsum = {1'b0, {(CW-HW){1'b0}}, head_reg} + {1'b0, count_reg};

    always_comb
    begin
        if (count_reg >= H_FULL)
        begin
            waddr  = head_reg;
            head1  = wrap_inc(head_reg);
            count1 = H_FULL;
        end
        else
        begin
            waddr  = (wsum >= (CW+1)'(HISTORY_DEPTH)) ?
                     HW'(wsum - (CW+1)'(HISTORY_DEPTH)) : HW'(wsum);
            head1  = head_reg;
            count1 = count_reg + 1'b1;
        end
        if (CMPW'(count1) > CMPW'(tau))
        begin
            head_next  = wrap_inc(head1);
            count_next = count1 - 1'b1;
        end
        else
        begin
            head_next  = head1;
            count_next = count1;
        end
    end

    assign we = (state_reg == S_WR);

    dbwc_ram #(
        .WIDTH (dbwc_pkg::TIME_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (sample_reg),
        .raddr (scan_addr_reg),
        .rdata (rdata)
    );

    assign queueing  = (standing_reg >= lowest_reg) ? standing_reg - lowest_reg : '0;
    assign div_start = (state_reg == S_MULQ);

    dbwc_div #(
        .NUM_W (NW),
        .DEN_W (WW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({vel_reg, {(2*F){1'b0}}}),
        .divisor  (window_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        w_x = XW'(window_reg);
        d_x = XW'(quotient);
        if (slow_reg && !cong_reg)
        begin
            nw_x = w_x + XW'(W_ONE);
        end
        else if (cong_reg)
        begin
            nw_x = (d_x >= w_x) ? '0 : w_x - d_x;
        end
        else
        begin
            nw_x = w_x + d_x;
        end
        if (nw_x < XW'(W_ONE))
        begin
            window_next = W_ONE;
        end
        else if (nw_x > XW'(W_MAX))
        begin
            window_next = W_MAX;
        end
        else
        begin
            window_next = WW'(nw_x);
        end
        slow_next = slow_reg && !cong_reg;
    end

    assign t5 = {3'b000, est_reg} + {1'b0, est_reg, 2'b00};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            gain_reg      <= dbwc_pkg::GAIN_RESET;
            vel_reg       <= dbwc_pkg::VEL_RESET;
            window_reg    <= W_ONE;
            slow_reg      <= 1'b1;
            est_reg       <= '0;
            lowest_reg    <= dbwc_pkg::LOWEST_RESET;
            head_reg      <= '0;
            count_reg     <= '0;
            rd_pend_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    dbwc_pkg::CFG_GAIN:     gain_reg <= cfg_data;
                    dbwc_pkg::CFG_VELOCITY: vel_reg  <= cfg_data[dbwc_pkg::VEL_W-1:0];
                    default: ;
                endcase
            end
            if (res_valid_reg && res_ready && state_reg != S_FIN)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (ack_valid)
                    begin
                        sample_reg <= sample_next;
                        state_reg  <= S_WR;
                    end
                end
                S_WR:
                begin
                    head_reg      <= head_next;
                    count_reg     <= count_next;
                    scan_addr_reg <= head_next;
                    scan_left_reg <= count_next;
                    rd_pend_reg   <= 1'b0;
                    standing_reg  <= '1;
                    if (sample_reg < lowest_reg)
                    begin
                        lowest_reg <= sample_reg;
                    end
                    first_reg   <= (est_reg == '0);
                    acc_reg     <= '0;
                    mcand_reg   <= {{(AW-EW-1){diff_next[EW]}}, diff_next};
                    gsh_reg     <= gain_eff;
                    mul_cnt_reg <= '0;
                    state_reg   <= S_MUL;
                end
                S_MUL:
                begin
                    if (gsh_reg[0])
                    begin
                        acc_reg <= acc_reg + mcand_reg;
                    end
                    mcand_reg   <= {mcand_reg[AW-2:0], 1'b0};
                    gsh_reg     <= {1'b0, gsh_reg[dbwc_pkg::GAIN_W-1:1]};
                    mul_cnt_reg <= mul_cnt_reg + 1'b1;
                    if (mul_cnt_reg == dbwc_pkg::MUL_LAST)
                    begin
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (mul_cnt_reg != '0)
                    begin
                        est_reg     <= est_next;
                        mul_cnt_reg <= '0;
                    end
                    if (scan_left_reg != '0)
                    begin
                        scan_addr_reg <= wrap_inc(scan_addr_reg);
                        scan_left_reg <= scan_left_reg - 1'b1;
                    end
                    rd_pend_reg <= (scan_left_reg != '0);
                    if (rd_pend_reg && rdata < standing_reg)
                    begin
                        standing_reg <= rdata;
                    end
                    if (scan_left_reg == '0 && !rd_pend_reg)
                    begin
                        state_reg <= S_MULQ;
                    end
                end
                S_MULQ:
                begin
                    prod_reg  <= PW'(window_reg) * PW'(queueing);
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    cong_reg  <= prod_reg > PW'({standing_reg, {F{1'b0}}});
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (!res_valid_reg || res_ready)
                    begin
                        window_reg                  <= window_next;
                        slow_reg                    <= slow_next;
                        res_valid_reg               <= 1'b1;
                        res_word_reg.window_packets <= window_next[WW-1:F];
                        res_word_reg.rto_ms         <= t5[EW+2:16];
                        res_word_reg.congested      <= cong_reg;
                        res_word_reg.in_slow_start  <= slow_next;
                        state_reg                   <= S_IDLE;
                    end
                    else
                    begin
                        res_valid_reg <= 1'b1;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign ack_ready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign res_valid = res_valid_reg;
    assign res_word  = res_word_reg;

endmodule
